/* rtl/rcfe_pkg.sv */
// shared types and constants for the rv64 control-flow execute block
// no dependencies; imported by every module of the block

package rcfe_pkg;

    localparam int XLEN_DEFAULT      = 64;
    localparam int REG_COUNT_DEFAULT = 32;

    // field widths of one instruction transaction and one result transaction
    localparam int OP_W    = 4;
    localparam int IDX_W   = 5;
    localparam int IMM_W   = 32;
    localparam int VALUE_W = 64;
    localparam int CFG_W   = 64;

    // input tdata layout, lowest bit first: op, dest_reg, src_reg_a, src_reg_b, imm_value
    localparam int S_OP_LO    = 0;
    localparam int S_RD_LO    = S_OP_LO + OP_W;
    localparam int S_RA_LO    = S_RD_LO + IDX_W;
    localparam int S_RB_LO    = S_RA_LO + IDX_W;
    localparam int S_IMM_LO   = S_RB_LO + IDX_W;
    localparam int S_USED_W   = S_IMM_LO + IMM_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // result tdata: next_pc, taken, write_enable, write_index, write_data
    localparam int M_USED_W   = VALUE_W + 1 + 1 + IDX_W + VALUE_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_USED_W;
    localparam int M_TUSER_W  = 1;

    localparam int PC_STEP  = 4;
    localparam int LSB_MASK = 1;

    typedef enum logic [OP_W-1:0] {
        OP_LUI   = 4'd0,
        OP_AUIPC = 4'd1,
        OP_JAL   = 4'd2,
        OP_JALR  = 4'd3,
        OP_BEQ   = 4'd4,
        OP_BNE   = 4'd5,
        OP_BLT   = 4'd6,
        OP_BGE   = 4'd7,
        OP_BLTU  = 4'd8,
        OP_BGEU  = 4'd9
    } op_t;

    typedef enum logic {
        ST_EXECUTED    = 1'b0,
        ST_UNSUPPORTED = 1'b1
    } status_t;

    // register file write port control
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } wr_ctl_t;

endpackage

/* rtl/rcfe_regfile.sv */
// integer register file: two read ports with registered data, one write port
// depends on rcfe_pkg; per-entry valid bits make every register read zero after reset

module rcfe_regfile #(
    parameter int XLEN      = rcfe_pkg::XLEN_DEFAULT,
    parameter int REG_COUNT = rcfe_pkg::REG_COUNT_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [rcfe_pkg::IDX_W-1:0]  ra_idx,
    input  logic [rcfe_pkg::IDX_W-1:0]  rb_idx,
    input  rcfe_pkg::wr_ctl_t           wr,
    input  logic [XLEN-1:0]             wr_data,
    output logic [XLEN-1:0]             ra_data,
    output logic [XLEN-1:0]             rb_data
);
    import rcfe_pkg::*;

    localparam int RIDX_W = $clog2(REG_COUNT);
    localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    logic [XLEN-1:0] mem_a_reg;
    logic [XLEN-1:0] mem_b_reg;
    logic [XLEN-1:0] fwd_data_reg;
    logic            a_fwd_reg;
    logic            b_fwd_reg;
    logic            a_live_reg;
    logic            b_live_reg;

    logic a_in_range;
    logic b_in_range;
    logic a_hit;
    logic b_hit;

    assign a_in_range = (ra_idx != '0) && ({1'b0, ra_idx} < REG_LIMIT);
    assign b_in_range = (rb_idx != '0) && ({1'b0, rb_idx} < REG_LIMIT);
    // a write landing in the same cycle as the read is forwarded
    assign a_hit = wr.en && (wr.idx == ra_idx);
    assign b_hit = wr.en && (wr.idx == rb_idx);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx[RIDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.idx[RIDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_a_reg    <= mem[ra_idx[RIDX_W-1:0]];
            mem_b_reg    <= mem[rb_idx[RIDX_W-1:0]];
            fwd_data_reg <= wr_data;
            a_fwd_reg    <= a_hit;
            b_fwd_reg    <= b_hit;
            a_live_reg   <= a_in_range && valid_reg[ra_idx[RIDX_W-1:0]];
            b_live_reg   <= b_in_range && valid_reg[rb_idx[RIDX_W-1:0]];
        end
    end

    assign ra_data = a_fwd_reg ? fwd_data_reg : (a_live_reg ? mem_a_reg : '0);
    assign rb_data = b_fwd_reg ? fwd_data_reg : (b_live_reg ? mem_b_reg : '0);

endmodule

/* rtl/riscv_control_flow_execute.sv */
// top level of the rv64 control-flow execute block: decode, branch compare, pc update
// depends on rcfe_pkg and rcfe_regfile

// Executes one decoded lui, auipc, jal, jalr or branch per cycle while m_tready
// stays high. An instruction transaction is taken into an input register (the
// register file is read at the same edge), evaluated, and its result is loaded into
// the output register when that register is empty or is being drained. That rate
// of one instruction per cycle rests on the loop through
// the pc register and the register file write, with the write forwarded into the
// read of the following instruction. Register x0 and indexes at or above
// REG_COUNT read zero; all registers read zero after reset through per-entry
// valid bits, with no clearing pass. A write on the cfg channel loads the pc
// directly and is meant only while no instruction is in flight; reset sets pc to 0.
// Ops 10 to 15 return status 1 with the pc unchanged and alter no state.

module riscv_control_flow_execute #(
    parameter int XLEN      = rcfe_pkg::XLEN_DEFAULT,
    parameter int REG_COUNT = rcfe_pkg::REG_COUNT_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // op, dest_reg, src_reg_a, src_reg_b, imm_value
    input  logic [rcfe_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // next_pc, taken, write_enable, write_index, write_data
    output logic [rcfe_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [rcfe_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcfe_pkg::CFG_W-1:0]      cfg_data
);
    import rcfe_pkg::*;

    localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REG_COUNT);

    // input stage
    logic             stage_valid_reg;
    op_t              op_reg;
    logic [IDX_W-1:0] rd_reg;
    logic [IMM_W-1:0] imm_reg;

    logic [XLEN-1:0] pc_reg;
    logic [XLEN-1:0] pc_next;

    // result register
    logic             m_tvalid_reg;
    logic [XLEN-1:0]  m_npc_reg;
    logic             m_taken_reg;
    logic             m_we_reg;
    logic [IDX_W-1:0] m_widx_reg;
    logic [XLEN-1:0]  m_wdata_reg;
    status_t          m_status_reg;

    logic [XLEN-1:0] rs_a;
    logic [XLEN-1:0] rs_b;
    logic [XLEN-1:0] imm_x;
    logic [XLEN-1:0] seq_pc;
    logic [XLEN-1:0] tgt_pc;
    logic [XLEN-1:0] jalr_pc;
    logic [XLEN-1:0] wdata;
    logic            wants_write;
    logic            wr_ok;
    logic            taken;
    logic            cond;
    status_t         status;

    logic    s_fire;
    logic    advance;
    wr_ctl_t wr;

    assign advance  = stage_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !stage_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_tready) begin
            stage_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg  <= op_t'(s_tdata[S_OP_LO +: OP_W]);
            rd_reg  <= s_tdata[S_RD_LO +: IDX_W];
            imm_reg <= s_tdata[S_IMM_LO +: IMM_W];
        end
    end

    assign wr.en  = advance && wr_ok;
    assign wr.idx = rd_reg;

    rcfe_regfile #(
        .XLEN      (XLEN),
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .ra_idx  (s_tdata[S_RA_LO +: IDX_W]),
        .rb_idx  (s_tdata[S_RB_LO +: IDX_W]),
        .wr      (wr),
        .wr_data (wdata),
        .ra_data (rs_a),
        .rb_data (rs_b)
    );

    assign imm_x   = XLEN'($signed(imm_reg));
    assign seq_pc  = pc_reg + XLEN'(PC_STEP);
    assign tgt_pc  = pc_reg + imm_x;
    assign jalr_pc = (rs_a + imm_x) & ~XLEN'(LSB_MASK);

    always_comb begin
        pc_next     = seq_pc;
        wdata       = seq_pc;
        wants_write = 1'b0;
        taken       = 1'b0;
        cond        = 1'b0;
        status      = ST_EXECUTED;
        unique case (op_reg)
            OP_LUI: begin
                wants_write = 1'b1;
                wdata       = imm_x;
            end
            OP_AUIPC: begin
                wants_write = 1'b1;
                wdata       = tgt_pc;
            end
            OP_JAL: begin
                wants_write = 1'b1;
                pc_next     = tgt_pc;
                taken       = 1'b1;
            end
            OP_JALR: begin
                wants_write = 1'b1;
                pc_next     = jalr_pc;
                taken       = 1'b1;
            end
            OP_BEQ:  cond = (rs_a == rs_b);
            OP_BNE:  cond = (rs_a != rs_b);
            OP_BLT:  cond = ($signed(rs_a) < $signed(rs_b));
            OP_BGE:  cond = ($signed(rs_a) >= $signed(rs_b));
            OP_BLTU: cond = (rs_a < rs_b);
            OP_BGEU: cond = (rs_a >= rs_b);
            default: begin
                pc_next = pc_reg;
                status  = ST_UNSUPPORTED;
            end
        endcase
        if (cond) begin
            pc_next = tgt_pc;
            taken   = 1'b1;
        end
        wr_ok = wants_write && (rd_reg != '0) && ({1'b0, rd_reg} < REG_LIMIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else if (cfg_valid) begin
            pc_reg <= cfg_data[XLEN-1:0];
        end else if (advance) begin
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_npc_reg    <= pc_next;
            m_taken_reg  <= taken;
            m_we_reg     <= wr_ok;
            m_widx_reg   <= wr_ok ? rd_reg : '0;
            m_wdata_reg  <= wr_ok ? wdata : '0;
            m_status_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, VALUE_W'(m_wdata_reg), m_widx_reg, m_we_reg,
                       m_taken_reg, VALUE_W'(m_npc_reg)};
    assign m_tuser  = M_TUSER_W'(m_status_reg);

endmodule

/* rtl/rcfe_checker.sv */
// port-level checks on the result channel of the control-flow execute block
// depends on rcfe_pkg; attached to riscv_control_flow_execute by the bind below

module rcfe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic [rcfe_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [rcfe_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import rcfe_pkg::*;

    localparam int TAKEN_BIT = VALUE_W;
    localparam int WE_BIT    = VALUE_W + 1;
    localparam int WIDX_LO   = VALUE_W + 2;
    localparam int WDATA_HI  = M_USED_W - 1;

    // a stalled result transaction holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // unsupported op neither redirects nor writes
    a_unsup_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[TAKEN_BIT] && !m_tdata[WE_BIT])
        else $error("unsupported op had side effects");

    // no write reported means index and data are zero
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[WE_BIT] |-> m_tdata[WDATA_HI:WIDX_LO] == '0)
        else $error("write fields nonzero without write_enable");

    // x0 is never reported as written
    a_no_x0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[WE_BIT] |-> m_tdata[WIDX_LO +: IDX_W] != '0)
        else $error("write to x0 reported");

    // synchronous reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind riscv_control_flow_execute rcfe_checker u_rcfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

/* dv/riscv_control_flow_execute_checker.sv */
// scoreboard for riscv_control_flow_execute: tracks pc and register file per transaction
// depends on rcfe_pkg; watches the instruction, result and cfg channels of the block
`timescale 1ns / 1ps

module riscv_control_flow_execute_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rcfe_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rcfe_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [rcfe_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rcfe_pkg::CFG_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import rcfe_pkg::*;

    // result tdata offsets, lowest bit first
    localparam int R_TAKEN_BIT = VALUE_W;
    localparam int R_WE_BIT    = VALUE_W + 1;
    localparam int R_IDX_LO    = VALUE_W + 2;
    localparam int R_DATA_LO   = R_IDX_LO + IDX_W;

    typedef struct packed {
        logic [VALUE_W-1:0] next_pc;
        logic               taken;
        logic               write_enable;
        logic [IDX_W-1:0]   write_index;
        logic [VALUE_W-1:0] write_data;
        logic               status;
    } retire_t;

    logic [VALUE_W-1:0] gpr [REG_COUNT_DEFAULT];
    logic [VALUE_W-1:0] pc_q;
    retire_t            retire_q[$];
    retire_t            got;
    retire_t            want;

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] seen,
                                   input logic [VALUE_W-1:0] wanted);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, seen, wanted);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [VALUE_W-1:0] seen,
                               input logic [VALUE_W-1:0] wanted);
        if (seen !== wanted)
            report_mismatch(what, seen, wanted);
    endtask

    function automatic logic [VALUE_W-1:0] read_gpr(input logic [IDX_W-1:0] idx);
        if (idx == 0 || idx >= REG_COUNT_DEFAULT)
            return '0;
        return gpr[idx];
    endfunction

    // executes one instruction against the tracked state
    function automatic retire_t retire_instr(input logic [S_TDATA_W-1:0] word);
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   rd;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] imm;
        logic [VALUE_W-1:0] seq;
        logic [VALUE_W-1:0] npc;
        logic [VALUE_W-1:0] wdata;
        logic               writes;
        logic               cond;
        logic               taken;
        retire_t            res;
        op     = word[S_OP_LO +: OP_W];
        rd     = word[S_RD_LO +: IDX_W];
        a      = read_gpr(word[S_RA_LO +: IDX_W]);
        b      = read_gpr(word[S_RB_LO +: IDX_W]);
        imm    = {{(VALUE_W-IMM_W){word[S_IMM_LO+IMM_W-1]}}, word[S_IMM_LO +: IMM_W]};
        seq    = pc_q + VALUE_W'(PC_STEP);
        npc    = seq;
        wdata  = '0;
        writes = 1'b0;
        cond   = 1'b0;
        taken  = 1'b0;
        res    = '0;
        if (op > OP_BGEU) begin
            res.next_pc = pc_q;
            res.status  = ST_UNSUPPORTED;
            return res;
        end
        case (op_t'(op))
            OP_LUI: begin
                writes = 1'b1;
                wdata  = imm;
            end
            OP_AUIPC: begin
                writes = 1'b1;
                wdata  = pc_q + imm;
            end
            OP_JAL: begin
                writes = 1'b1;
                wdata  = seq;
                npc    = pc_q + imm;
                taken  = 1'b1;
            end
            OP_JALR: begin
                // rs1 was read above, so rd == rs1 sees the old value
                writes = 1'b1;
                wdata  = seq;
                npc    = (a + imm) & ~VALUE_W'(LSB_MASK);
                taken  = 1'b1;
            end
            OP_BEQ:  cond = (a == b);
            OP_BNE:  cond = (a != b);
            OP_BLT:  cond = ($signed(a) < $signed(b));
            OP_BGE:  cond = ($signed(a) >= $signed(b));
            OP_BLTU: cond = (a < b);
            default: cond = (a >= b);
        endcase
        if (op >= OP_BEQ && cond) begin
            npc   = pc_q + imm;
            taken = 1'b1;
        end
        if (writes && rd != 0 && rd < REG_COUNT_DEFAULT) begin
            gpr[rd]          = wdata;
            res.write_enable = 1'b1;
            res.write_index  = rd;
            res.write_data   = wdata;
        end
        pc_q        = npc;
        res.next_pc = npc;
        res.taken   = taken;
        res.status  = ST_EXECUTED;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT_DEFAULT; i++)
                gpr[i] = '0;
            pc_q = '0;
            mismatches = 0;
            retire_q.delete();
        end else begin
            // results first: a transaction accepted at this edge cannot answer itself
            if (m_tvalid && m_tready) begin
                got.next_pc      = m_tdata[0 +: VALUE_W];
                got.taken        = m_tdata[R_TAKEN_BIT];
                got.write_enable = m_tdata[R_WE_BIT];
                got.write_index  = m_tdata[R_IDX_LO +: IDX_W];
                got.write_data   = m_tdata[R_DATA_LO +: VALUE_W];
                got.status       = m_tuser[0];
                if (retire_q.size() == 0) begin
                    report_mismatch("unexpected result", got.next_pc, '0);
                end else begin
                    want = retire_q.pop_front();
                    check_field("next_pc", got.next_pc, want.next_pc);
                    check_field("taken", VALUE_W'(got.taken), VALUE_W'(want.taken));
                    check_field("write_enable", VALUE_W'(got.write_enable),
                                VALUE_W'(want.write_enable));
                    check_field("write_index", VALUE_W'(got.write_index),
                                VALUE_W'(want.write_index));
                    check_field("write_data", got.write_data, want.write_data);
                    check_field("status", VALUE_W'(got.status), VALUE_W'(want.status));
                end
            end
            if (cfg_valid && cfg_ready)
                pc_q = cfg_data;
            if (s_tvalid && s_tready)
                retire_q.push_back(retire_instr(s_tdata));
        end
        pending = retire_q.size();
    end

endmodule

/* dv/riscv_control_flow_execute_test.sv */
// top of the riscv_control_flow_execute testbench: clock, reset, stimulus and verdict
// depends on rcfe_pkg, riscv_control_flow_execute and riscv_control_flow_execute_checker
`timescale 1ns / 1ps

module riscv_control_flow_execute_test;
    import rcfe_pkg::*;

    localparam int OP_CODE_MAX  = (1 << OP_W) - 1;
    localparam int PHASE_COUNT  = 4;
    localparam int PHASE_ITEMS  = 200;

    localparam logic [IMM_W-1:0] IMM_CORNERS [6] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5000
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int          mismatches;
    int          pending;
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int unsigned      idle_plan  [PHASE_COUNT];
    int unsigned      stall_plan [PHASE_COUNT];
    logic [CFG_W-1:0] start_plan [PHASE_COUNT];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    riscv_control_flow_execute DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    riscv_control_flow_execute_checker scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #2_000_000;
        $display("FAIL riscv_control_flow_execute");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_instr(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] rd,
                              input logic [IDX_W-1:0] ra, input logic [IDX_W-1:0] rb,
                              input logic [IMM_W-1:0] imm);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_OP_LO +: OP_W]   = op;
        word[S_RD_LO +: IDX_W]  = rd;
        word[S_RA_LO +: IDX_W]  = ra;
        word[S_RB_LO +: IDX_W]  = rb;
        word[S_IMM_LO +: IMM_W] = imm;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_start(input logic [CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge aclk);
    endtask

    function automatic logic [IDX_W-1:0] pick_reg;
        // a narrow pool makes equal operands and rd == rs1 frequent
        if ($urandom_range(1))
            return IDX_W'($urandom_range(3));
        return IDX_W'($urandom_range(31));
    endfunction

    task automatic send_random;
        logic [OP_W-1:0]  op;
        logic [IMM_W-1:0] imm;
        int unsigned      pick;
        pick = $urandom_range(99);
        if (pick < 28)
            op = OP_LUI;
        else if (pick < 36)
            op = OP_AUIPC;
        else if (pick < 44)
            op = OP_JAL;
        else if (pick < 52)
            op = OP_JALR;
        else if (pick < 92)
            op = OP_W'($urandom_range(OP_BGEU, OP_BEQ));
        else
            op = OP_W'($urandom_range(OP_CODE_MAX, OP_BGEU + 1));
        case ($urandom_range(3))
            0:       imm = IMM_W'($urandom_range(31)) - IMM_W'(16);
            1:       imm = IMM_CORNERS[$urandom_range(5)];
            default: imm = $urandom;
        endcase
        send_instr(op, pick_reg(), pick_reg(), pick_reg(), imm);
    endtask

    initial begin
        idle_plan  = '{0, 57, 0, 26};
        stall_plan = '{0, 0, 57, 26};
        start_plan[0] = {CFG_W{1'b1}};
        start_plan[1] = '0;
        start_plan[2] = {$urandom, $urandom};
        start_plan[3] = 64'h7FFF_FFFF_FFFF_FFF8;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed part runs from the reset pc of zero
        send_instr(OP_LUI,   5'd1,  5'd0,  5'd0,  32'h8000_0000);
        send_instr(OP_LUI,   5'd2,  5'd31, 5'd31, 32'h7FFF_F000);
        send_instr(OP_LUI,   5'd0,  5'd0,  5'd0,  32'hFFFF_FFFF);
        send_instr(OP_AUIPC, 5'd31, 5'd0,  5'd0,  32'hFFFF_FFFC);
        send_instr(OP_JAL,   5'd3,  5'd0,  5'd0,  32'h7FFF_FFFE);
        send_instr(OP_JAL,   5'd4,  5'd0,  5'd0,  32'h8000_0000);
        send_instr(OP_JALR,  5'd5,  5'd1,  5'd0,  32'h0000_0001);
        send_instr(OP_BEQ,   5'd0,  5'd2,  5'd2,  32'h0000_0010);
        send_instr(OP_BEQ,   5'd0,  5'd1,  5'd2,  32'h0000_0010);
        send_instr(OP_BNE,   5'd0,  5'd1,  5'd2,  32'hFFFF_FFF8);
        send_instr(OP_BNE,   5'd0,  5'd0,  5'd0,  32'hFFFF_FFF8);
        send_instr(OP_BLT,   5'd0,  5'd1,  5'd2,  32'h0000_0020);
        send_instr(OP_BLT,   5'd0,  5'd2,  5'd1,  32'h0000_0020);
        send_instr(OP_BGE,   5'd0,  5'd2,  5'd1,  32'h0000_0040);
        send_instr(OP_BGE,   5'd0,  5'd1,  5'd2,  32'h0000_0040);
        send_instr(OP_BGE,   5'd0,  5'd0,  5'd0,  32'h0000_0004);
        send_instr(OP_BLTU,  5'd0,  5'd2,  5'd1,  32'hFFFF_FFF0);
        send_instr(OP_BLTU,  5'd0,  5'd1,  5'd2,  32'hFFFF_FFF0);
        send_instr(OP_BGEU,  5'd0,  5'd1,  5'd2,  32'h0000_0008);
        send_instr(OP_BGEU,  5'd0,  5'd0,  5'd1,  32'h0000_0008);
        send_instr(OP_W'(OP_BGEU + 1), 5'd31, 5'd1, 5'd2, 32'hFFFF_FFFF);
        send_instr(OP_W'(OP_CODE_MAX), 5'd7,  5'd2, 5'd1, 32'h7FFF_FFFF);
        send_instr(OP_JALR,  5'd1,  5'd1,  5'd0,  32'h0000_0003);
        send_instr(OP_LUI,   5'd31, 5'd0,  5'd0,  32'h0000_0000);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_start(start_plan[p]);
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            drain();
        end

        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS riscv_control_flow_execute");
        else
            $display("FAIL riscv_control_flow_execute");
        $finish;
    end

endmodule

/* riscv_control_flow_execute.f */
rtl/rcfe_pkg.sv
rtl/rcfe_regfile.sv
rtl/riscv_control_flow_execute.sv
rtl/rcfe_checker.sv
dv/riscv_control_flow_execute_checker.sv
dv/riscv_control_flow_execute_test.sv
